/* hdl/apq_pkg.sv */
// Shared types and codes for the array priority queue
`timescale 1ns / 1ps
package apq_pkg;

	// field widths of one request and one result
	localparam int MODE_W  = 2;
	localparam int VALUE_W = 32;
	localparam int PRIO_W  = 16;
	localparam int STAT_W  = 2;
	localparam int OCC_W   = 5;

	// operation codes
	localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
	localparam logic [MODE_W-1:0] MODE_FIFO   = 2'd1;
	localparam logic [MODE_W-1:0] MODE_PRIO   = 2'd2;

	// status codes
	localparam logic [STAT_W-1:0] STAT_DONE  = 2'd0;
	localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
	localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd2;

	typedef struct packed {
		logic [MODE_W-1:0]         mode;
		logic signed [VALUE_W-1:0] item_value;
		logic [PRIO_W-1:0]         item_priority;
	} req_t;

	typedef struct packed {
		logic [STAT_W-1:0]         status;
		logic signed [VALUE_W-1:0] removed_value;
		logic [PRIO_W-1:0]         removed_priority;
		logic [OCC_W-1:0]          occupancy;
	} res_t;

	// one stored pair
	typedef struct packed {
		logic signed [VALUE_W-1:0] value;
		logic [PRIO_W-1:0]         prio;
	} entry_t;

endpackage

/* hdl/apq_mem.sv */
// Entry store: one write port, one read port with registered read data
`timescale 1ns / 1ps
module apq_mem #(
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  apq_pkg::entry_t          wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output apq_pkg::entry_t          rdata
);
	import apq_pkg::*;

	entry_t mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read port, registered read data
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* hdl/array_priority_queue_top.sv */
// Array priority queue: controller around a circular entry store
`timescale 1ns / 1ps
// Holds up to DEPTH value/priority pairs in arrival order in one synchronous
// memory. A request is taken when start is high and busy is low; its result
// shows on result for exactly one cycle with done high and cannot be held
// off, so the receiver must take it then. Insert registers its result in the
// dispatch state; oldest-dequeue reads the head there and registers it in a
// separate read state. Lowest-priority dequeue reads every held entry once
// through the single read port (one per cycle) to find the minimum, earliest
// on ties, then reads and writes back each later entry to close the gap.
// busy stays high until the result is issued; the next request may be taken
// in the cycle that done is high.
module array_priority_queue_top #(
	parameter int DEPTH = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  apq_pkg::req_t request,
	output logic          done,
	output apq_pkg::res_t result
);
	import apq_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	// controller states
	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_DISP  = 3'd1;
	localparam logic [2:0] S_FRD   = 3'd2;
	localparam logic [2:0] S_SCAN  = 3'd3;
	localparam logic [2:0] S_SHIFT = 3'd4;

	logic [2:0]        state_q;
	req_t              req_q;
	logic [AW-1:0]     head_q;
	logic [CW-1:0]     count_q;
	logic [CW-1:0]     issue_q;
	logic              vld_s1;
	logic [CW-1:0]     idx_s1;
	logic [CW-1:0]     best_idx_q;
	logic [PRIO_W-1:0] best_pri_q;
	logic signed [VALUE_W-1:0] best_val_q;
	logic              done_q;
	res_t              result_q;

	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	entry_t        mem_wdata;
	logic          mem_re;
	logic [AW-1:0] mem_raddr;
	entry_t        mem_rdata;

	logic          issue_ok;
	logic          take_new;
	logic [CW-1:0] nb_idx;

	// logical position to physical slot, modulo DEPTH
	function automatic logic [AW-1:0] phys(input logic [AW-1:0] head,
			input logic [CW-1:0] pos);
		logic [CW:0] sum;
		sum = (CW+1)'(head) + (CW+1)'(pos);
		if (sum >= (CW+1)'(DEPTH)) begin
			sum = sum - (CW+1)'(DEPTH);
		end
		return sum[AW-1:0];
	endfunction

	apq_mem #(.DEPTH(DEPTH)) u_mem (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.re   (mem_re),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	// scan compare on returning read data
	assign issue_ok = issue_q < count_q;
	assign take_new = vld_s1 && ((idx_s1 == '0) || (mem_rdata.prio < best_pri_q));
	assign nb_idx   = take_new ? idx_s1 : best_idx_q;

	// memory port control
	always_comb begin
		mem_re    = 1'b0;
		mem_raddr = phys(head_q, issue_q);
		mem_we    = 1'b0;
		mem_waddr = phys(head_q, idx_s1 - CW'(1));
		mem_wdata = mem_rdata;
		case (state_q)
			S_DISP: begin
				if ((req_q.mode == MODE_FIFO || req_q.mode == MODE_PRIO)
						&& count_q != '0) begin
					mem_re    = 1'b1;
					mem_raddr = head_q;
				end
				if (req_q.mode == MODE_INSERT && count_q != CW'(DEPTH)) begin
					mem_we          = 1'b1;
					mem_waddr       = phys(head_q, count_q);
					mem_wdata.value = req_q.item_value;
					mem_wdata.prio  = req_q.item_priority;
				end
			end
			S_SCAN: begin
				mem_re = issue_ok;
			end
			S_SHIFT: begin
				mem_re = issue_ok;
				mem_we = vld_s1;
			end
			default: begin
			end
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			head_q  <= '0;
			count_q <= '0;
			vld_s1  <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						req_q   <= request;
						state_q <= S_DISP;
					end
				end
				S_DISP: begin
					result_q.removed_value    <= '0;
					result_q.removed_priority <= '0;
					result_q.status           <= STAT_DONE;
					result_q.occupancy        <= OCC_W'(count_q);
					case (req_q.mode)
						MODE_INSERT: begin
							done_q  <= 1'b1;
							state_q <= S_IDLE;
							if (count_q == CW'(DEPTH)) begin
								result_q.status <= STAT_FULL;
							end else begin
								count_q            <= count_q + CW'(1);
								result_q.occupancy <= OCC_W'(count_q + CW'(1));
							end
						end
						MODE_FIFO, MODE_PRIO: begin
							if (count_q == '0) begin
								result_q.status <= STAT_EMPTY;
								done_q          <= 1'b1;
								state_q         <= S_IDLE;
							end else if (req_q.mode == MODE_FIFO) begin
								state_q <= S_FRD;
							end else begin
								issue_q <= CW'(1);
								vld_s1  <= 1'b1;
								idx_s1  <= '0;
								state_q <= S_SCAN;
							end
						end
						default: begin
							done_q  <= 1'b1;
							state_q <= S_IDLE;
						end
					endcase
				end
				S_FRD: begin
					result_q.status           <= STAT_DONE;
					result_q.removed_value    <= mem_rdata.value;
					result_q.removed_priority <= mem_rdata.prio;
					result_q.occupancy        <= OCC_W'(count_q - CW'(1));
					head_q                    <= phys(head_q, CW'(1));
					count_q                   <= count_q - CW'(1);
					done_q                    <= 1'b1;
					state_q                   <= S_IDLE;
				end
				S_SCAN: begin
					vld_s1 <= issue_ok;
					idx_s1 <= issue_q;
					if (issue_ok) begin
						issue_q <= issue_q + CW'(1);
					end
					if (take_new) begin
						best_idx_q <= idx_s1;
						best_pri_q <= mem_rdata.prio;
						best_val_q <= mem_rdata.value;
					end
					// last entry compared: start closing the gap
					if (vld_s1 && idx_s1 == count_q - CW'(1)) begin
						issue_q <= nb_idx + CW'(1);
						vld_s1  <= 1'b0;
						state_q <= S_SHIFT;
					end
				end
				S_SHIFT: begin
					vld_s1 <= issue_ok;
					idx_s1 <= issue_q;
					if (issue_ok) begin
						issue_q <= issue_q + CW'(1);
					end
					if (!issue_ok && !vld_s1) begin
						result_q.status           <= STAT_DONE;
						result_q.removed_value    <= best_val_q;
						result_q.removed_priority <= best_pri_q;
						result_q.occupancy        <= OCC_W'(count_q - CW'(1));
						count_q                   <= count_q - CW'(1);
						done_q                    <= 1'b1;
						state_q                   <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// outputs
	assign busy   = state_q != S_IDLE;
	assign done   = done_q;
	assign result = result_q;

endmodule

/* dv/tb_array_priority_queue_top.sv */
// Testbench for the array priority queue: queued request driver, result monitor, predictor
`timescale 1ns / 1ps
module tb_array_priority_queue_top;
	import apq_pkg::*;

	localparam int DEPTH = 16;
	localparam int RAND_ITEMS = 1650;
	localparam int DRAIN_CYCLES = 2 * DEPTH + 16;
	localparam int PRINT_CAP = 40;
	// mode three does nothing and has no code in the package
	localparam logic [MODE_W-1:0] MODE_NOP = 2'd3;

	// one queued request and the sender idle rate that goes with it
	typedef struct {
		req_t        req;
		int unsigned idle_pct;
	} stim_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	req_t request = '0;
	logic busy;
	logic done;
	res_t result;

	stim_t stim_queue[$];
	res_t  outcome_queue[$];
	int    error_count = 0;

	// predicted store contents
	logic signed [VALUE_W-1:0] q_values[DEPTH];
	logic [PRIO_W-1:0]         q_prios[DEPTH];
	logic [3:0]                q_head = '0;
	logic [OCC_W-1:0]          q_count = '0;

	array_priority_queue_top #(
		.DEPTH(DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.request(request),
		.done(done),
		.result(result)
	);

	// clock
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// physical slot of a logical position in the circular store
	function automatic int slot_of(int pos);
		return (int'(q_head) + pos) % DEPTH;
	endfunction

	// apply one request to the predicted store and return its result
	function automatic res_t serve_request(req_t rq);
		res_t              r;
		int                best;
		int                i;
		logic [PRIO_W-1:0] best_prio;
		r = '0;
		r.status = STAT_DONE;
		case (rq.mode)
			MODE_INSERT: begin
				if (q_count >= DEPTH) begin
					r.status = STAT_FULL;
				end else begin
					q_values[slot_of(q_count)] = rq.item_value;
					q_prios[slot_of(q_count)] = rq.item_priority;
					q_count = q_count + 1'b1;
				end
			end
			MODE_FIFO: begin
				if (q_count == 0) begin
					r.status = STAT_EMPTY;
				end else begin
					r.removed_value = q_values[q_head];
					r.removed_priority = q_prios[q_head];
					q_head = q_head + 1'b1;
					q_count = q_count - 1'b1;
				end
			end
			MODE_PRIO: begin
				if (q_count == 0) begin
					r.status = STAT_EMPTY;
				end else begin
					// lowest number wins, earliest arrival on ties
					best = 0;
					best_prio = q_prios[slot_of(0)];
					for (i = 1; i < q_count; i++) begin
						if (q_prios[slot_of(i)] < best_prio) begin
							best_prio = q_prios[slot_of(i)];
							best = i;
						end
					end
					r.removed_value = q_values[slot_of(best)];
					r.removed_priority = best_prio;
					// close the gap, keeping arrival order
					for (i = best + 1; i < q_count; i++) begin
						q_values[slot_of(i - 1)] = q_values[slot_of(i)];
						q_prios[slot_of(i - 1)] = q_prios[slot_of(i)];
					end
					q_count = q_count - 1'b1;
				end
			end
			default: begin
			end
		endcase
		r.occupancy = q_count;
		return r;
	endfunction

	// one line per mismatch, printing capped, counting not
	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
		error_count++;
		if (error_count <= PRINT_CAP)
			$display("%0t mismatch %s: got %0h expected %0h", $realtime, what, got, want);
	endtask

	task automatic add_item(logic [MODE_W-1:0] m, logic [VALUE_W-1:0] v,
		logic [PRIO_W-1:0] p, int unsigned pct);
		stim_t s;
		s.req.mode = m;
		s.req.item_value = v;
		s.req.item_priority = p;
		s.idle_pct = pct;
		stim_queue.push_back(s);
	endtask

	// driver: take the front request on acceptance, then offer the next one
	always @(posedge clk) begin
		if (!arst_n) begin
			start <= 1'b0;
		end else begin
			if (start && !busy) begin
				outcome_queue.push_back(serve_request(request));
				void'(stim_queue.pop_front());
			end
			if (start && busy) begin
				// request still pending, hold it
			end else if (stim_queue.size() != 0 &&
				$urandom_range(99) >= stim_queue[0].idle_pct) begin
				start <= 1'b1;
				request <= stim_queue[0].req;
			end else begin
				start <= 1'b0;
			end
		end
	end

	// monitor: every strobed result against the oldest prediction
	always @(posedge clk) begin
		res_t want;
		if (arst_n && done) begin
			if (outcome_queue.size() == 0) begin
				report_mismatch("result with no request outstanding", 64'(result), '0);
			end else begin
				want = outcome_queue.pop_front();
				if (result.status !== want.status)
					report_mismatch("status", 64'(result.status), 64'(want.status));
				if (result.removed_value !== want.removed_value)
					report_mismatch("removed_value", 64'(result.removed_value),
						64'(want.removed_value));
				if (result.removed_priority !== want.removed_priority)
					report_mismatch("removed_priority", 64'(result.removed_priority),
						64'(want.removed_priority));
				if (result.occupancy !== want.occupancy)
					report_mismatch("occupancy", 64'(result.occupancy),
						64'(want.occupancy));
			end
		end
	end

	// stimulus, reset and end of run
	initial begin
		int unsigned phase_idle[4];
		int                n;
		int                k;
		int                blk_len;
		int                ins_pct;
		logic [MODE_W-1:0] m;
		logic [PRIO_W-1:0] p;
		logic [VALUE_W-1:0] v;

		phase_idle = '{0, 61, 0, 24};
		for (n = 0; n < DEPTH; n++) begin
			q_values[n] = '0;
			q_prios[n] = '0;
		end

		// removals and no-op on an empty store
		add_item(MODE_FIFO, $urandom, PRIO_W'($urandom), 0);
		add_item(MODE_PRIO, $urandom, PRIO_W'($urandom), 0);
		add_item(MODE_NOP, $urandom, PRIO_W'($urandom), 0);
		// fill with extremes and tied priorities
		for (n = 0; n < DEPTH; n++) begin
			case (n)
				0: add_item(MODE_INSERT, 32'h7fff_ffff, 16'hffff, 0);
				1: add_item(MODE_INSERT, 32'h8000_0000, 16'h0000, 0);
				2: add_item(MODE_INSERT, 32'hffff_ffff, 16'h8000, 0);
				3: add_item(MODE_INSERT, 32'h0000_0000, 16'h0000, 0);
				default: add_item(MODE_INSERT, $urandom, (n % 2) ? 16'd5 : 16'd9, 0);
			endcase
		end
		// insert refused when full, no-op when full
		add_item(MODE_INSERT, 32'h1234_5678, 16'h0001, 0);
		add_item(MODE_NOP, $urandom, PRIO_W'($urandom), 0);
		// tie on zero, then oldest, then the other zero, then tie on five
		add_item(MODE_PRIO, $urandom, PRIO_W'($urandom), 0);
		add_item(MODE_FIFO, $urandom, PRIO_W'($urandom), 0);
		add_item(MODE_PRIO, $urandom, PRIO_W'($urandom), 0);
		add_item(MODE_PRIO, $urandom, PRIO_W'($urandom), 0);

		// random blocks biased toward filling, draining or neither
		n = 0;
		while (n < RAND_ITEMS) begin
			blk_len = $urandom_range(60, 15);
			case ($urandom_range(2))
				0: ins_pct = 75;
				1: ins_pct = 25;
				default: ins_pct = 50;
			endcase
			for (k = 0; k < blk_len && n < RAND_ITEMS; k++) begin
				if ($urandom_range(99) < 3)
					m = MODE_NOP;
				else if ($urandom_range(99) < ins_pct)
					m = MODE_INSERT;
				else
					m = $urandom_range(1) ? MODE_PRIO : MODE_FIFO;
				case ($urandom_range(3))
					0: p = PRIO_W'($urandom_range(7));
					1: p = $urandom_range(1) ? 16'hffff : 16'h0000;
					default: p = PRIO_W'($urandom);
				endcase
				case ($urandom_range(7))
					0: v = 32'h8000_0000;
					1: v = 32'h7fff_ffff;
					default: v = $urandom;
				endcase
				add_item(m, v, p, phase_idle[(n * 4) / RAND_ITEMS]);
				n++;
			end
		end

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		wait (stim_queue.size() == 0);
		wait (outcome_queue.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (outcome_queue.size() != 0)
			report_mismatch("results never arrived", 64'(outcome_queue.size()), '0);
		if (error_count == 0) begin
			$display("tb_array_priority_queue_top: clean");
		end else begin
			$display("tb_array_priority_queue_top: errors");
		end
		$finish;
	end

	// watchdog
	initial begin
		#3_000_000;
		$display("tb_array_priority_queue_top: errors");
		$finish;
	end

endmodule
